// ===== rtl/core/scmel_pkg.sv =====
// Shared types and constants for the structured cell min edge length block.
// No dependencies.
package scmel_pkg;

  localparam int SIZE_W = 17;
  localparam int LEN_W  = 25;
  localparam int STAT_W = 2;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FLAT = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

  localparam logic [1:0] REG_SIZE_I = 2'd0;
  localparam logic [1:0] REG_SIZE_J = 2'd1;
  localparam logic [1:0] REG_SIZE_K = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIVK, S_DIVJ, S_CLAMP, S_ADDR, S_READ, S_LATCH,
    S_EDGE, S_SQRT, S_OUT
  } state_t;

endpackage

// ===== rtl/core/scmel_ram.sv =====
// Generic single port write, single port registered read RAM.
// No dependencies.
module scmel_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/scmel_sqrt.sv =====
// Bit serial floor square root, one result bit per cycle.
// Depends on nothing.
module scmel_sqrt #(
  parameter int IN_W = 52
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [IN_W-1:0]     radicand,
  output logic                done,
  output logic [IN_W/2-1:0]   root
);
  localparam int RW = IN_W / 2;
  localparam int CW = $clog2(RW + 1);

  logic [IN_W-1:0] rem;
  logic [IN_W-1:0] acc;
  logic [RW-1:0]   q;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [IN_W+1:0] trial;
  logic [IN_W+1:0] shifted;

  assign shifted = {rem, acc[IN_W-1:IN_W-2]};
  assign trial   = shifted - {{(IN_W-RW){1'b0}}, q, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(RW);
        acc  <= radicand;
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        acc <= acc << 2;
        if (!trial[IN_W+1]) begin
          rem <= trial[IN_W-1:0];
          q   <= {q[RW-2:0], 1'b1};
        end else begin
          rem <= shifted[IN_W-1:0];
          q   <= {q[RW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = q;
endmodule

// ===== rtl/core/structured_cell_min_edge_length.sv =====
// Top level of the structured cell min edge length block.
// Depends on scmel_pkg, scmel_ram, scmel_sqrt.
//
// Usage: in channel (in_valid/in_stall) carries op, index and coordinates.
// op 0 writes a vertex into the coordinate memory and gives
// no result. op 1 queries the hexahedral cell at index, stepped back on
// each axis of size above one where index is in the last layer; one result
// (min_length, status) leaves on the out channel (out_valid/out_stall). The
// block takes one item at a time and holds in_stall high while it works.
// A query runs: range check, index split by two restoring divisions, then
// a read of each corner through one shared read port, an evaluation of each
// edge through one shared squared distance unit, and a bit serial square root.
// Bad or flat queries go from the range check straight to the result.
// The result register holds while out_stall is high and no new item is
// taken until it leaves. Reset clears the sizes to one and best_square
// to zero; memory contents stay undefined until written.
// Size registers are written on cfg_valid with cfg_ready always high.
module structured_cell_min_edge_length #(
  parameter int MAX_VERTICES = 65536,
  parameter int COORD_BITS   = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [15:0] index,
  input  logic signed [23:0] coord_x,
  input  logic signed [23:0] coord_y,
  input  logic signed [23:0] coord_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [24:0] min_length,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int DW  = COORD_BITS + 1;
  localparam int SQW = 2 * DW;
  localparam int SUMW = SQW + 2;
  localparam int RTW = SUMW / 2 + (SUMW % 2);
  localparam int LW = scmel_pkg::LEN_W;

  logic [16:0] size_i, size_j, size_k;
  logic [49:0] best_square;
  scmel_pkg::state_t state, state_next;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      size_i <= 17'd1; size_j <= 17'd1; size_k <= 17'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        scmel_pkg::REG_SIZE_I: size_i <= cfg_data;
        scmel_pkg::REG_SIZE_J: size_j <= cfg_data;
        scmel_pkg::REG_SIZE_K: size_k <= cfg_data;
        default: ;
      endcase
    end
  end

  // memory
  logic          we;
  logic [AW-1:0] raddr;
  logic [COORD_BITS-1:0] rx, ry, rz;
  logic [AW:0]   widx;
  assign widx = (AW+1)'(index);
  assign we = in_valid && !in_stall && !op && (widx < (AW+1)'(MAX_VERTICES));

  scmel_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_x (.clk, .we,
    .waddr(AW'(index)), .wdata(COORD_BITS'(coord_x)), .raddr, .rdata(rx));
  scmel_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_y (.clk, .we,
    .waddr(AW'(index)), .wdata(COORD_BITS'(coord_y)), .raddr, .rdata(ry));
  scmel_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_VERTICES)) u_z (.clk, .we,
    .waddr(AW'(index)), .wdata(COORD_BITS'(coord_z)), .raddr, .rdata(rz));

  // query registers
  logic [15:0] qidx;
  logic [33:0] plane;
  logic [16:0] ci, cj, ck;
  logic [33:0] dnum;       // shifting dividend
  logic [33:0] drem;
  logic [16:0] dquo;
  logic [4:0]  dcnt;
  logic [33:0] ddiv;
  logic        fa, fb, fg;
  logic [2:0]  corner;
  logic        phase;
  logic [33:0] base;
  logic [COORD_BITS-1:0] cx [8];
  logic [COORD_BITS-1:0] cy [8];
  logic [COORD_BITS-1:0] cz [8];
  logic [3:0]  edge_n;
  logic [1:0]  esub;
  logic [SUMW-1:0] sum;
  logic [SUMW-1:0] best;
  logic        sq_start, sq_done;
  logic [RTW-1:0] root;
  logic [LW-1:0] len_r;
  logic [1:0]  stat_r;

  // corner offsets
  logic [33:0] offa, offb, offg, caddr;
  assign offa = corner[0] && fa ? 34'd1 : 34'd0;
  assign offb = corner[1] && fb ? 34'(size_i) : 34'd0;
  assign offg = corner[2] && fg ? plane : 34'd0;
  assign caddr = base + offa + offb + offg;

  // edge table: corner bit order {g,b,a}; edge n -> pair, enable
  logic [2:0] ea, eb;
  logic       een;
  always_comb begin
    unique case (edge_n[3:2])
      2'd0: begin ea = {edge_n[1], edge_n[0], 1'b0}; eb = ea | 3'b001; een = fa; end
      2'd1: begin ea = {edge_n[1], 1'b0, edge_n[0]}; eb = ea | 3'b010; een = fb; end
      default: begin ea = {1'b0, edge_n[1], edge_n[0]}; eb = ea | 3'b100; een = fg; end
    endcase
  end

  logic [DW-1:0] dsel, dabs;
  logic [COORD_BITS-1:0] pa, pb;
  always_comb begin
    unique case (esub)
      2'd0: begin pa = cx[ea]; pb = cx[eb]; end
      2'd1: begin pa = cy[ea]; pb = cy[eb]; end
      default: begin pa = cz[ea]; pb = cz[eb]; end
    endcase
    dsel = {pa[COORD_BITS-1], pa} - {pb[COORD_BITS-1], pb};
    dabs = dsel[DW-1] ? -dsel : dsel;
  end
  logic [SQW-1:0] sqr;
  always_ff @(posedge clk) sqr <= dabs * dabs;

  logic [33:0] dshift, dtrial;
  logic        dbit;
  assign dshift = {drem[32:0], dnum[33]};
  assign dtrial = dshift - ddiv;
  assign dbit   = !dtrial[33] || drem[33];

  logic [50:0] total_c;
  assign total_c = plane * size_k;
  logic flat, badc;
  assign flat = size_i == 1 && size_j == 1 && size_k == 1;
  assign badc = size_i == 0 || size_j == 0 || size_k == 0 || size_i > 17'd65536 ||
                size_j > 17'd65536 || size_k > 17'd65536 ||
                total_c > 51'(MAX_VERTICES) || 51'(qidx) >= total_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scmel_pkg::S_IDLE;
      best_square <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        scmel_pkg::S_IDLE: if (in_valid && op) begin
          qidx <= index;
          plane <= size_i * size_j;
        end
        scmel_pkg::S_CHECK: begin
          dcnt <= 5'd0;
          if (badc || flat) begin
            len_r  <= scmel_pkg::LEN_MAX;
            stat_r <= badc ? scmel_pkg::ST_BAD : scmel_pkg::ST_FLAT;
          end
        end
        scmel_pkg::S_DIVK, scmel_pkg::S_DIVJ: begin
          if (dcnt == 5'd0) begin
            dnum <= (state == scmel_pkg::S_DIVK) ? {17'(qidx), 17'd0}
                                                 : {drem[16:0], 17'd0};
            drem <= '0; dquo <= '0; dcnt <= 5'd1;
            ddiv <= (state == scmel_pkg::S_DIVK) ? plane : 34'(size_i);
          end else begin
            dnum <= dnum << 1;
            drem <= dbit ? dtrial : dshift;
            dquo <= {dquo[15:0], dbit};
            dcnt <= (dcnt == 5'd17) ? 5'd0 : dcnt + 1'b1;
            if (dcnt == 5'd17) begin
              if (state == scmel_pkg::S_DIVK) begin
                ck <= {dquo[15:0], dbit};
              end else begin
                cj <= {dquo[15:0], dbit};
                ci <= 17'(dbit ? dtrial : dshift);
              end
            end
          end
        end
        scmel_pkg::S_CLAMP: begin
          fa <= size_i > 17'd1; fb <= size_j > 17'd1; fg <= size_k > 17'd1;
          if (size_i > 17'd1 && ci == size_i - 17'd1) ci <= ci - 1'b1;
          if (size_j > 17'd1 && cj == size_j - 17'd1) cj <= cj - 1'b1;
          if (size_k > 17'd1 && ck == size_k - 17'd1) ck <= ck - 1'b1;
        end
        scmel_pkg::S_ADDR: begin
          base <= 34'(ci) + 34'(cj * size_i) + 34'(ck) * plane;
          corner <= '0; phase <= 1'b0;
        end
        scmel_pkg::S_READ: begin
          raddr <= AW'(caddr);
          phase <= 1'b0;
        end
        scmel_pkg::S_LATCH: begin
          phase <= ~phase;
          if (phase) begin
            cx[corner] <= rx; cy[corner] <= ry; cz[corner] <= rz;
            corner <= corner + 1'b1;
            if (corner == 3'd7) begin
              edge_n <= '0; esub <= '0; sum <= '0; best <= '1;
            end
          end
        end
        scmel_pkg::S_EDGE: begin
          // sqr is registered, so it holds the square for the esub of the cycle before
          esub <= (esub == 2'd3) ? 2'd0 : esub + 1'b1;
          if (esub == 2'd3) begin
            if (een && (sum + SUMW'(sqr)) < best) best <= sum + SUMW'(sqr);
            sum <= '0;
            edge_n <= edge_n + 1'b1;
          end else if (esub != 2'd0) begin
            sum <= sum + SUMW'(sqr);
          end
        end
        scmel_pkg::S_SQRT: if (sq_done) begin
          best_square <= best[49:0];
          len_r <= (root > RTW'(scmel_pkg::LEN_MAX)) ? scmel_pkg::LEN_MAX : LW'(root);
          stat_r <= scmel_pkg::ST_OK;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    sq_start = 1'b0;
    unique case (state)
      scmel_pkg::S_IDLE:  if (in_valid && op) state_next = scmel_pkg::S_CHECK;
      scmel_pkg::S_CHECK: state_next = (badc || flat) ? scmel_pkg::S_OUT : scmel_pkg::S_DIVK;
      scmel_pkg::S_DIVK:  if (dcnt == 5'd17) state_next = scmel_pkg::S_DIVJ;
      scmel_pkg::S_DIVJ:  if (dcnt == 5'd17) state_next = scmel_pkg::S_CLAMP;
      scmel_pkg::S_CLAMP: state_next = scmel_pkg::S_ADDR;
      scmel_pkg::S_ADDR:  state_next = scmel_pkg::S_READ;
      scmel_pkg::S_READ:  state_next = scmel_pkg::S_LATCH;
      scmel_pkg::S_LATCH: if (phase) state_next = (corner == 3'd7) ? scmel_pkg::S_EDGE
                                                                   : scmel_pkg::S_READ;
      scmel_pkg::S_EDGE:  if (esub == 2'd3 && edge_n == 4'd11) begin
        state_next = scmel_pkg::S_SQRT;
        sq_start = 1'b1;
      end
      scmel_pkg::S_SQRT:  if (sq_done) state_next = scmel_pkg::S_OUT;
      scmel_pkg::S_OUT:   if (!out_stall) state_next = scmel_pkg::S_IDLE;
      default: state_next = scmel_pkg::S_IDLE;
    endcase
  end

  logic [SUMW-1:0] best_fin;
  assign best_fin = (een && (sum + SUMW'(sqr)) < best) ? sum + SUMW'(sqr) : best;
  logic [SUMW-1:0] sq_in;
  always_ff @(posedge clk) if (sq_start) sq_in <= best_fin;
  logic sq_go;
  always_ff @(posedge clk) sq_go <= rst ? 1'b0 : sq_start;

  scmel_sqrt #(.IN_W(2*RTW)) u_sqrt (.clk, .rst, .start(sq_go),
    .radicand((2*RTW)'(sq_in)), .done(sq_done), .root);

  assign in_stall   = state != scmel_pkg::S_IDLE;
  assign out_valid  = state == scmel_pkg::S_OUT;
  assign min_length = len_r;
  assign status     = stat_r;
  logic unused;
  assign unused = ^best_square;
endmodule

// ===== rtl/core/scmel_checker.sv =====
// Port level checker for structured_cell_min_edge_length, with its bind.
// Depends on scmel_pkg.
module scmel_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        op,
  input logic        out_valid,
  input logic        out_stall,
  input logic [24:0] min_length,
  input logic [1:0]  status
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(min_length) && $stable(status))
    else $error("result changed under stall");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("item taken with result pending");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == scmel_pkg::ST_OK || status == scmel_pkg::ST_FLAT ||
                  status == scmel_pkg::ST_BAD) else $error("bad status");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != scmel_pkg::ST_OK |-> min_length == scmel_pkg::LEN_MAX)
    else $error("error result not saturated");
  a_query: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op |=> in_stall) else $error("query not started");
endmodule

bind structured_cell_min_edge_length scmel_checker u_chk (.clk, .rst, .in_valid,
  .in_stall, .op, .out_valid, .out_stall, .min_length, .status);

// ===== test/tb_structured_cell_min_edge_length.sv =====
// Testbench for structured_cell_min_edge_length: vertex writes and cell queries
// checked against an in-bench predictor of the shortest cell edge.
// Depends on scmel_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_structured_cell_min_edge_length;

  localparam int NVERT = 65536;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = 1'b0;
  logic [15:0] index = '0;
  logic signed [23:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [24:0] min_length;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [16:0] cfg_data = '0;

  structured_cell_min_edge_length i_dut (.*);

  always #10 clk = ~clk;

  typedef struct packed {
    logic [24:0] len;
    logic [1:0]  st;
  } cell_res_t;

  logic signed [23:0] vx [NVERT];
  logic signed [23:0] vy [NVERT];
  logic signed [23:0] vz [NVERT];
  bit written [NVERT];
  longint unsigned sz_i, sz_j, sz_k;
  cell_res_t pending_q[$];

  int errors = 0, mism = 0, n_items = 0, n_res = 0, cycles = 0;
  int send_idle = 37, recv_idle = 46;
  bit hold_recv = 1'b0;

  function automatic longint unsigned edge_sq(longint unsigned a, longint unsigned b);
    longint signed dx, dy, dz;
    dx = longint'(vx[a]) - longint'(vx[b]);
    dy = longint'(vy[a]) - longint'(vy[b]);
    dz = longint'(vz[a]) - longint'(vz[b]);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r = 0, bt = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic cell_res_t query_cell(longint unsigned idx);
    cell_res_t res;
    longint unsigned plane, total, kk, rem, jj, ii, a, b, g, va, vb, vc, vd, off, best, d;
    res.len = scmel_pkg::LEN_MAX;
    res.st = scmel_pkg::ST_BAD;
    if (sz_i == 0 || sz_j == 0 || sz_k == 0 || sz_i > 65536 || sz_j > 65536 || sz_k > 65536)
      return res;
    plane = sz_i * sz_j;
    total = plane * sz_k;
    if (total > NVERT || idx >= total) return res;
    if (sz_i == 1 && sz_j == 1 && sz_k == 1) begin
      res.st = scmel_pkg::ST_FLAT;
      return res;
    end
    kk = idx / plane;
    rem = idx - kk * plane;
    jj = rem / sz_i;
    ii = rem - jj * sz_i;
    a = 64'(sz_i > 1); b = 64'(sz_j > 1); g = 64'(sz_k > 1);
    if (a != 0 && ii == sz_i - 1) ii--;
    if (b != 0 && jj == sz_j - 1) jj--;
    if (g != 0 && kk == sz_k - 1) kk--;
    va = ii + jj * sz_i + kk * plane;
    vb = va + a;
    vd = va + b * sz_i;
    vc = vd + a;
    off = g * plane;
    best = 64'hFFFF_FFFF_FFFF_FFFF;
    if (a != 0) begin
      d = edge_sq(va, vb); if (d < best) best = d;
      d = edge_sq(vd, vc); if (d < best) best = d;
      d = edge_sq(va + off, vb + off); if (d < best) best = d;
      d = edge_sq(vd + off, vc + off); if (d < best) best = d;
    end
    if (b != 0) begin
      d = edge_sq(va, vd); if (d < best) best = d;
      d = edge_sq(vb, vc); if (d < best) best = d;
      d = edge_sq(va + off, vd + off); if (d < best) best = d;
      d = edge_sq(vb + off, vc + off); if (d < best) best = d;
    end
    if (g != 0) begin
      d = edge_sq(va, va + off); if (d < best) best = d;
      d = edge_sq(vb, vb + off); if (d < best) best = d;
      d = edge_sq(vd, vd + off); if (d < best) best = d;
      d = edge_sq(vc, vc + off); if (d < best) best = d;
    end
    d = floor_root(best);
    res.len = d > 64'(scmel_pkg::LEN_MAX) ? scmel_pkg::LEN_MAX : d[24:0];
    res.st = scmel_pkg::ST_OK;
    return res;
  endfunction

  // Cell is valid to query only if every vertex of the mesh is written; a zero or oversized mesh counts as written.
  function automatic bit mesh_written();
    longint unsigned t = sz_i * sz_j * sz_k;
    if (sz_i == 0 || sz_j == 0 || sz_k == 0 || t > NVERT) return 1'b1;
    for (int v = 0; v < t; v++) if (!written[v]) return 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    cell_res_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      n_res++;
      if (pending_q.size() == 0) begin
        errors++;
        if (mism++ < 10) $display("unexpected result len=%0d st=%0d", min_length, status);
      end else begin
        exp_r = pending_q.pop_front();
        if (exp_r.len !== min_length || exp_r.st !== status) begin
          errors++;
          if (mism++ < 10)
            $display("mismatch: exp len=%0d st=%0d got len=%0d st=%0d",
                     exp_r.len, exp_r.st, min_length, status);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic write_reg(logic [1:0] ri, logic [16:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (ri)
      scmel_pkg::REG_SIZE_I: sz_i = 64'(val);
      scmel_pkg::REG_SIZE_J: sz_j = 64'(val);
      scmel_pkg::REG_SIZE_K: sz_k = 64'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid before the sender waits on anything else.
  task automatic idle_in();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic set_mesh(int si, int sj, int sk);
    idle_in();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    write_reg(scmel_pkg::REG_SIZE_I, si[16:0]);
    write_reg(scmel_pkg::REG_SIZE_J, sj[16:0]);
    write_reg(scmel_pkg::REG_SIZE_K, sk[16:0]);
  endtask

  // Drive one item; predicts on acceptance. Sender gaps are random when gaps is set.
  task automatic send_item(bit o, logic [15:0] ix, logic [23:0] x, logic [23:0] y,
                           logic [23:0] z, bit gaps);
    @(negedge clk);
    while (gaps && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    index <= ix;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    if (!o) begin
      vx[ix] = x; vy[ix] = y; vz[ix] = z;
      written[ix] = 1'b1;
    end else begin
      pending_q.push_back(query_cell(64'(ix)));
    end
  endtask

  task automatic fill_mesh(int mode);
    longint unsigned t = sz_i * sz_j * sz_k;
    logic [23:0] x, y, z;
    for (int v = 0; v < t; v++) begin
      case (mode)
        0: begin x = 24'($urandom); y = 24'($urandom); z = 24'($urandom); end
        1: begin
          x = 24'($urandom_range(4095));
          y = 24'($urandom_range(4095));
          z = 24'($urandom_range(4095));
        end
        default: begin x = 24'(v * 16); y = 24'((v % 3) * 64); z = 24'(-v); end
      endcase
      send_item(1'b0, v[15:0], x, y, z, 1'b1);
    end
  endtask

  task automatic rand_query(bit broken);
    longint unsigned t = sz_i * sz_j * sz_k;
    logic [15:0] ix;
    if (broken || t > NVERT || t == 0) ix = 16'($urandom);
    else ix = 16'($urandom_range(32'(t - 1)));
    send_item(1'b1, ix, 24'($urandom), 24'($urandom), 24'($urandom), 1'b1);
  endtask

  typedef struct {
    bit o;
    logic [15:0] ix;
    logic [23:0] x, y, z;
    bit known;
    cell_res_t r;
  } row_t;

  row_t dir_tab [4];

  initial begin
    for (int v = 0; v < NVERT; v++) written[v] = 1'b0;
    sz_i = 1; sz_j = 1; sz_k = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: flat mesh after reset, extremes, edge layers
    dir_tab = '{
      '{1'b0, 16'd0, 24'h7FFFFF, 24'h800000, 24'h000000, 1'b0, '0},
      '{1'b1, 16'd0, 24'h0, 24'h0, 24'h0, 1'b1, '{scmel_pkg::LEN_MAX, scmel_pkg::ST_FLAT}},
      '{1'b1, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1,
        '{scmel_pkg::LEN_MAX, scmel_pkg::ST_BAD}},
      '{1'b0, 16'hFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 1'b0, '0}
    };
    foreach (dir_tab[n]) begin
      send_item(dir_tab[n].o, dir_tab[n].ix, dir_tab[n].x, dir_tab[n].y, dir_tab[n].z, 1'b0);
      if (dir_tab[n].known && dir_tab[n].r != pending_q[$]) begin
        errors++;
        $display("directed row %0d predictor disagrees with table", n);
      end
    end
    set_mesh(2, 2, 2);
    fill_mesh(0);
    send_item(1'b0, 16'd1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_item(1'b0, 16'd0, 24'h800000, 24'h800000, 24'h800000, 1'b0);
    for (int q = 0; q < 9; q++) send_item(1'b1, q[15:0], 24'h0, 24'h0, 24'h0, 1'b0);
    set_mesh(0, 2, 2);
    send_item(1'b1, 16'd0, 24'd0, 24'd0, 24'd0, 1'b0);
    set_mesh(65536, 1, 1);
    send_item(1'b1, 16'd5, 24'd0, 24'd0, 24'd0, 1'b0);
    set_mesh(65537, 1, 1);
    send_item(1'b1, 16'd0, 24'd0, 24'd0, 24'd0, 1'b0);
    set_mesh(256, 256, 2);
    send_item(1'b1, 16'd0, 24'd0, 24'd0, 24'd0, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 37 : (ph == 1 ? 46 : 0);
      recv_idle = ph == 0 ? 46 : (ph == 1 ? 37 : 0);
      for (int m = 0; m < 4; m++) begin
        int si, sj, sk;
        si = $urandom_range(1, 5); sj = $urandom_range(1, 4); sk = $urandom_range(1, 4);
        if (m == 3) begin si = 1; sj = 1; sk = $urandom_range(2, 6); end
        set_mesh(si, sj, sk);
        fill_mesh($urandom_range(2));
        if (!mesh_written()) $display("mesh incomplete");
        for (int q = 0; q < 120; q++) begin
          if ($urandom_range(9) == 0)
            send_item(1'b0, 16'($urandom_range(si * sj * sk - 1)),
                      24'($urandom), 24'($urandom), 24'($urandom), 1'b1);
          else rand_query($urandom_range(9) == 0);
        end
      end
      if (ph == 0) begin
        fork
          begin
            hold_recv = 1'b1;
            repeat (400) @(posedge clk);
            hold_recv = 1'b0;
          end
          for (int q = 0; q < 6; q++) rand_query(1'b0);
        join
        idle_in();
        while (pending_q.size() != 0) @(posedge clk);
      end
    end
    set_mesh(1, 1, 1);
    send_item(1'b1, 16'd0, 24'd0, 24'd0, 24'd0, 1'b1);
    idle_in();

    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("ran %0d items, %0d results, over several mesh shapes and flat/bad cases",
             n_items, n_res);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
